[rtl/core/rlcm_pkg.sv]
// Shared types and constants for the running least-common-multiple accumulator.
package rlcm_pkg;

  // Default width of the running value.
  localparam int unsigned LCM_WIDTH_DEF = 32;
  // Width of one input period.
  localparam int unsigned PERIOD_W = 16;
  // Width of the reported value.
  localparam int unsigned OUT_W = 32;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV_MOD,
    ST_GCD_START,
    ST_GCD,
    ST_DIV_QUO,
    ST_MUL_START,
    ST_MUL,
    ST_WRITE
  } state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DIV_MOD_START,
    OP_DIV_STEP,
    OP_GCD_START,
    OP_GCD_STEP,
    OP_DIV_QUO_START,
    OP_MUL_START,
    OP_MUL_STEP,
    OP_COMMIT
  } dp_op_t;

  // How the running value is updated at commit.
  typedef enum logic [1:0] {
    CK_RESTART,
    CK_ZERO,
    CK_SAT,
    CK_MUL
  } commit_t;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_t  op;
    commit_t kind;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic restart;
    logic zero_case;
    logic sat_case;
    logic iter_last;
    logic gcd_done;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/core/rlcm_ctrl.sv]
// Sequencing state machine for the running least-common-multiple accumulator.
module rlcm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rlcm_pkg::dp_stat_t stat,
  output rlcm_pkg::dp_cmd_t  cmd
);
  import rlcm_pkg::*;

  state_t  state_r, state_nxt;
  commit_t kind_r, kind_nxt;

  // State and commit-kind registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= CK_ZERO;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // The input side is open only between items.
  assign in_stall = (state_r != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd.op    = OP_NONE;
    cmd.kind  = kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.restart) begin
          kind_nxt  = CK_RESTART;
          state_nxt = ST_WRITE;
        end else if (stat.zero_case) begin
          kind_nxt  = CK_ZERO;
          state_nxt = ST_WRITE;
        end else if (stat.sat_case) begin
          kind_nxt  = CK_SAT;
          state_nxt = ST_WRITE;
        end else begin
          cmd.op    = OP_DIV_MOD_START;
          state_nxt = ST_DIV_MOD;
        end
      end
      ST_DIV_MOD: begin
        cmd.op = OP_DIV_STEP;
        if (stat.iter_last) begin
          state_nxt = ST_GCD_START;
        end
      end
      ST_GCD_START: begin
        cmd.op    = OP_GCD_START;
        state_nxt = ST_GCD;
      end
      ST_GCD: begin
        if (stat.gcd_done) begin
          cmd.op    = OP_DIV_QUO_START;
          state_nxt = ST_DIV_QUO;
        end else begin
          cmd.op = OP_GCD_STEP;
        end
      end
      ST_DIV_QUO: begin
        cmd.op = OP_DIV_STEP;
        if (stat.iter_last) begin
          state_nxt = ST_MUL_START;
        end
      end
      ST_MUL_START: begin
        cmd.op    = OP_MUL_START;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.op = OP_MUL_STEP;
        if (stat.iter_last) begin
          kind_nxt  = CK_MUL;
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // Commit only when the output register can take the result.
        if (stat.out_free) begin
          cmd.op    = OP_COMMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // A commit always returns the controller to idle.
  a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_COMMIT) |=> (state_r == ST_IDLE))
    else $error("commit did not return to idle");

  // An item is captured only from idle.
  a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_CAPTURE) |-> (state_r == ST_IDLE && !in_stall))
    else $error("capture outside idle");

  // A fold result is committed only after the multiply pass.
  a_mul_before_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && stat.iter_last) |=> (state_r == ST_WRITE && kind_r == CK_MUL))
    else $error("multiply pass did not lead to commit");
`endif

endmodule

[rtl/core/rlcm_dp.sv]
// Datapath: running value, serial divider, binary gcd unit and serial multiplier.
module rlcm_dp #(
  parameter int unsigned LCM_WIDTH = rlcm_pkg::LCM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [rlcm_pkg::PERIOD_W-1:0]  in_period,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rlcm_pkg::OUT_W-1:0]     out_lcm_value,
  output logic                           out_overflow,
  input  rlcm_pkg::dp_cmd_t              cmd,
  output rlcm_pkg::dp_stat_t             stat
);
  import rlcm_pkg::*;

  localparam int unsigned AW = LCM_WIDTH + PERIOD_W;
  localparam int unsigned CMAX = (LCM_WIDTH > PERIOD_W) ? LCM_WIDTH : PERIOD_W;
  localparam int unsigned CW = $clog2(CMAX + 1);
  localparam logic [63:0] MAXV64 = {64{1'b1}} >> (64 - LCM_WIDTH);
  localparam logic [LCM_WIDTH-1:0] MAXV = {LCM_WIDTH{1'b1}};

  // Captured item.
  logic [PERIOD_W-1:0]  p_r, p_nxt;
  logic                 restart_r, restart_nxt;
  // Running state.
  logic [LCM_WIDTH-1:0] run_r, run_nxt;
  logic                 sticky_r, sticky_nxt;
  // Divider.
  logic [LCM_WIDTH-1:0] dvd_r, dvd_nxt;
  logic [PERIOD_W-1:0]  rem_r, rem_nxt;
  logic [PERIOD_W-1:0]  div_r, div_nxt;
  // Gcd unit.
  logic [PERIOD_W-1:0]  a_r, a_nxt;
  logic [PERIOD_W-1:0]  b_r, b_nxt;
  logic [3:0]           k_r, k_nxt;
  // Multiplier.
  logic [AW-1:0]        acc_r, acc_nxt;
  logic [PERIOD_W-1:0]  pm_r, pm_nxt;
  // Shared step counter.
  logic [CW-1:0]        cnt_r, cnt_nxt;
  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_val_r, out_val_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  // Intermediate values.
  logic [PERIOD_W:0]    rem_shift;
  logic [PERIOD_W-1:0]  gval;
  logic [PERIOD_W-1:0]  gcd_val;
  logic [63:0]          run64;
  logic                 out_free;

  assign rem_shift = {rem_r, dvd_r[LCM_WIDTH-1]};
  assign gval      = a_r | b_r;
  assign gcd_val   = gval << k_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Status toward the controller.
  assign stat.restart   = restart_r;
  assign stat.zero_case = (p_r == '0) || (run_r == '0);
  assign stat.sat_case  = sticky_r;
  assign stat.iter_last = (cnt_r == CW'(1));
  assign stat.gcd_done  = (a_r == '0) || (b_r == '0);
  assign stat.out_free  = out_free;

  // Control and running-state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    restart_r <= restart_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    k_r       <= k_nxt;
    acc_r     <= acc_nxt;
    pm_r      <= pm_nxt;
    cnt_r     <= cnt_nxt;
    out_val_r <= out_val_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  // Next values for every operation.
  always_comb begin
    p_nxt         = p_r;
    restart_nxt   = restart_r;
    run_nxt       = run_r;
    sticky_nxt    = sticky_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    pm_nxt        = pm_r;
    cnt_nxt       = cnt_r;
    out_val_nxt   = out_val_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    run64         = 64'(run_r);
    case (cmd.op)
      OP_CAPTURE: begin
        p_nxt       = in_period;
        restart_nxt = in_restart;
      end
      // Restoring division of the running value, one quotient bit a step.
      OP_DIV_MOD_START: begin
        dvd_nxt = run_r;
        rem_nxt = '0;
        div_nxt = p_r;
        cnt_nxt = CW'(LCM_WIDTH);
      end
      OP_DIV_QUO_START: begin
        dvd_nxt = run_r;
        rem_nxt = '0;
        div_nxt = gcd_val;
        cnt_nxt = CW'(LCM_WIDTH);
      end
      OP_DIV_STEP: begin
        if (rem_shift >= {1'b0, div_r}) begin
          rem_nxt = PERIOD_W'(rem_shift - {1'b0, div_r});
          dvd_nxt = {dvd_r[LCM_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt = rem_shift[PERIOD_W-1:0];
          dvd_nxt = {dvd_r[LCM_WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
      end
      // Binary gcd of the period and the remainder.
      OP_GCD_START: begin
        a_nxt = p_r;
        b_nxt = rem_r;
        k_nxt = '0;
      end
      OP_GCD_STEP: begin
        if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 4'd1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r >= b_r) begin
          a_nxt = a_r - b_r;
        end else begin
          b_nxt = b_r - a_r;
        end
      end
      // Shift-and-add product of the quotient and the period, MSB first.
      OP_MUL_START: begin
        acc_nxt = '0;
        pm_nxt  = p_r;
        cnt_nxt = CW'(PERIOD_W);
      end
      OP_MUL_STEP: begin
        acc_nxt = {acc_r[AW-2:0], 1'b0} + (pm_r[PERIOD_W-1] ? AW'(dvd_r) : AW'(0));
        pm_nxt  = {pm_r[PERIOD_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
      end
      // Update the running value and load the output register.
      OP_COMMIT: begin
        case (cmd.kind)
          CK_RESTART: begin
            if (64'(p_r) > MAXV64) begin
              run_nxt    = MAXV;
              sticky_nxt = 1'b1;
            end else begin
              run_nxt    = LCM_WIDTH'(p_r);
              sticky_nxt = 1'b0;
            end
          end
          CK_ZERO: begin
            run_nxt = '0;
          end
          CK_SAT: begin
            run_nxt = MAXV;
          end
          CK_MUL: begin
            if (acc_r[AW-1:LCM_WIDTH] != '0) begin
              run_nxt    = MAXV;
              sticky_nxt = 1'b1;
            end else begin
              run_nxt = acc_r[LCM_WIDTH-1:0];
            end
          end
          default: begin
            run_nxt = run_r;
          end
        endcase
        run64         = 64'(run_nxt);
        out_val_nxt   = run64[OUT_W-1:0];
        out_ovf_nxt   = sticky_nxt;
        out_valid_nxt = 1'b1;
      end
      default: begin
        run64 = 64'(run_r);
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_lcm_value = out_val_r;
  assign out_overflow  = out_ovf_r;

`ifndef SYNTHESIS
  // The partial remainder stays below the divisor after each division step.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DIV_STEP) |=> (rem_r < div_r))
    else $error("division remainder out of range");

  // Gcd steps run only on two nonzero operands.
  a_gcd_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_GCD_STEP) |-> (a_r != '0 && b_r != '0))
    else $error("gcd step on a zero operand");

  // A set sticky flag goes with a saturated or zero running value.
  a_sticky_value: assert property (@(posedge clk) disable iff (!rst_n)
    sticky_r |-> (run_r == MAXV || run_r == '0))
    else $error("sticky flag without saturated value");

  // A result is never committed over one that is still waiting.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_COMMIT) |-> (!out_valid_r || !out_stall))
    else $error("result overwritten");
`endif

endmodule

[rtl/core/running_lcm_accumulator_top.sv]
// Top level of the running least-common-multiple accumulator.
//
// Input channel: in_period and in_restart, transferred when in_valid is high
// and in_stall is low. A restart item starts a new list with its period as
// the running value and clears the overflow flag; every other item folds its
// period into the running value as the least common multiple.
// Result channel: one result per item on out_lcm_value and out_overflow,
// transferred when out_valid is high and out_stall is low.
// One item is worked on at a time; in_stall is low only while idle.
// Restart, zero and already-saturated items go from the decide state straight
// to the write state and skip the arithmetic.
// A fold runs two passes of the bit-serial divider (one bit a cycle), the
// binary gcd loop and a shift-and-add multiply.
// A finished result waits in the output register; the next item is taken
// meanwhile, and its commit waits while the receiver stalls.
// Reset clears the running value, the internal overflow flag and out_valid; out_overflow itself is not reset.
module running_lcm_accumulator_top #(
  parameter int unsigned LCM_WIDTH = rlcm_pkg::LCM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rlcm_pkg::PERIOD_W-1:0] in_period,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rlcm_pkg::OUT_W-1:0]    out_lcm_value,
  output logic                          out_overflow
);
  import rlcm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  rlcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and result register.
  rlcm_dp #(
    .LCM_WIDTH (LCM_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_period     (in_period),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_lcm_value (out_lcm_value),
    .out_overflow  (out_overflow),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
